// ===== hw/rtl/rfpw_pkg.sv =====
// rfpw_pkg: shared types and constants of the rectangle fill pixel writer
// used by every module of the block; depends on nothing

package rfpw_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FILL_ENABLE    = 3'd0;
  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd1;
  localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_LINE_PITCH     = 3'd3;
  localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd4;
  localparam logic [2:0] REG_BASE_ADDRESS   = 3'd5;

  localparam int CfgDataW = 48;
  localparam int SideW    = 14;
  localparam int PitchW   = 16;
  localparam int OutAddrW = 48;

  // command codes of an input word and of a queue entry
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // pixel depths and write sizes
  localparam logic [7:0] BPP_32  = 8'd32;
  localparam logic [7:0] BPP_24  = 8'd24;
  localparam logic [2:0] BYTES_3 = 3'd3;
  localparam logic [2:0] BYTES_4 = 3'd4;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // queue slots between front and back
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic                fill_enable;
    logic [SideW-1:0]    screen_width;
    logic [SideW-1:0]    screen_height;
    logic [PitchW-1:0]   line_pitch;
    logic [7:0]          bits_per_pixel;
    logic [CfgDataW-1:0] base_address;
  } cfg_t;

endpackage

// ===== hw/rtl/rfpw_front.sv =====
// rfpw_front: classifies input words, clips start rectangles, drops ignored starts
// and forms the row offset product; depends on rfpw_pkg

module rfpw_front #(
  parameter int MAX_SIDE = 8192
) (
  input  logic                            word_accept,
  input  logic                            cmd,
  input  logic [15:0]                     rect_x,
  input  logic [15:0]                     rect_y,
  input  logic [15:0]                     rect_width,
  input  logic [15:0]                     rect_height,
  input  logic [31:0]                     fill_colour,
  input  rfpw_pkg::cfg_t                  cfg,
  output logic                            push,
  output logic                            entry_kind,
  output logic [$clog2(MAX_SIDE)-1:0]     entry_x,
  output logic [$clog2(MAX_SIDE)-1:0]     entry_y,
  output logic [$clog2(MAX_SIDE+1)-1:0]   entry_end_col,
  output logic [$clog2(MAX_SIDE+1)-1:0]   entry_end_row,
  output logic [31:0]                     entry_colour,
  output logic [$clog2(MAX_SIDE)+15:0]    entry_prod
);

  localparam int PosW = $clog2(MAX_SIDE);
  localparam int EndW = $clog2(MAX_SIDE + 1);
  localparam int ProdW = PosW + rfpw_pkg::PitchW;
  localparam logic [16:0] MaxSide17 = 17'(MAX_SIDE);

  logic [16:0] sw;
  logic [16:0] sh;
  logic [16:0] x_end;
  logic [16:0] y_end;
  logic        depth_ok;
  logic        start_ok;

  // screen sides are limited to the largest supported side
  assign sw = (17'(cfg.screen_width) > MaxSide17) ? MaxSide17 : 17'(cfg.screen_width);
  assign sh = (17'(cfg.screen_height) > MaxSide17) ? MaxSide17 : 17'(cfg.screen_height);

  assign depth_ok = (cfg.bits_per_pixel == rfpw_pkg::BPP_32) ||
                    (cfg.bits_per_pixel == rfpw_pkg::BPP_24);

  assign start_ok = cfg.fill_enable && depth_ok &&
                    (17'(rect_x) < sw) && (17'(rect_y) < sh) &&
                    (rect_width != 16'd0) && (rect_height != 16'd0);

  // sums kept one bit wider so they never wrap
  assign x_end = 17'(rect_x) + 17'(rect_width);
  assign y_end = 17'(rect_y) + 17'(rect_height);

  assign push          = word_accept && ((cmd == rfpw_pkg::CMD_ADVANCE) || start_ok);
  assign entry_kind    = cmd;
  assign entry_x       = PosW'(rect_x);
  assign entry_y       = PosW'(rect_y);
  assign entry_end_col = EndW'((x_end > sw) ? sw : x_end);
  assign entry_end_row = EndW'((y_end > sh) ? sh : y_end);
  assign entry_colour  = fill_colour;
  assign entry_prod    = ProdW'(entry_y) * ProdW'(cfg.line_pitch);

endmodule

// ===== hw/rtl/rfpw_queue.sv =====
// rfpw_queue: small first-in first-out buffer between front and back
// depends on rfpw_pkg for its depth

module rfpw_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int Depth = rfpw_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/rfpw_back.sv =====
// rfpw_back: fill state, pixel address generation and the output register
// depends on rfpw_pkg

module rfpw_back #(
  parameter int MAX_SIDE     = 8192,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rfpw_pkg::cfg_t                  cfg,
  input  logic                            entry_valid,
  input  logic                            entry_kind,
  input  logic [$clog2(MAX_SIDE)-1:0]     entry_x,
  input  logic [$clog2(MAX_SIDE)-1:0]     entry_y,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   entry_end_col,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   entry_end_row,
  input  logic [31:0]                     entry_colour,
  input  logic [$clog2(MAX_SIDE)+15:0]    entry_prod,
  output logic                            pop,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [rfpw_pkg::OutAddrW-1:0]   write_address,
  output logic [31:0]                     write_data,
  output logic [2:0]                      byte_count,
  output logic                            last
);

  localparam int PosW = $clog2(MAX_SIDE);
  localparam int EndW = $clog2(MAX_SIDE + 1);
  localparam int AW   = ADDRESS_BITS;

  logic            busy;
  logic [PosW-1:0] left_column;
  logic [PosW-1:0] current_column;
  logic [PosW-1:0] current_row;
  logic [EndW-1:0] end_column;
  logic [EndW-1:0] end_row;
  logic [31:0]     held_colour;
  logic [AW-1:0]   row_address;

  logic            out_free;
  logic            four_bytes;
  logic            depth_ok;
  logic            do_start;
  logic            do_advance;
  logic            do_abort;
  logic [EndW:0]   col_inc;
  logic [EndW:0]   row_inc;
  logic            col_end;
  logic            row_end;
  logic [PosW+1:0] col_offset;
  logic [AW-1:0]   pixel_address;
  logic [AW-1:0]   next_row_address;
  logic [AW-1:0]   start_row_address;

  assign out_free   = !out_valid || out_ready;
  assign pop        = entry_valid && out_free;
  assign four_bytes = (cfg.bits_per_pixel == rfpw_pkg::BPP_32);
  assign depth_ok   = four_bytes || (cfg.bits_per_pixel == rfpw_pkg::BPP_24);

  assign do_start   = pop && (entry_kind == rfpw_pkg::CMD_START);
  assign do_advance = pop && (entry_kind == rfpw_pkg::CMD_ADVANCE) && busy &&
                      cfg.fill_enable && depth_ok;
  // registers went bad under a running fill: drop it silently
  assign do_abort   = pop && (entry_kind == rfpw_pkg::CMD_ADVANCE) && busy &&
                      !(cfg.fill_enable && depth_ok);

  assign col_inc = (EndW+1)'(current_column) + 1'b1;
  assign row_inc = (EndW+1)'(current_row) + 1'b1;
  assign col_end = (col_inc >= {1'b0, end_column});
  assign row_end = (row_inc >= {1'b0, end_row});

  // column times 4, or times 3 as 2x + x
  assign col_offset = four_bytes ? {current_column, 2'b00}
                                 : ({1'b0, current_column, 1'b0} + {2'b00, current_column});

  assign pixel_address     = row_address + AW'(col_offset);
  assign next_row_address  = row_address + AW'(cfg.line_pitch);
  assign start_row_address = AW'(cfg.base_address) + AW'(entry_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= do_advance;
      end
      if (do_start) begin
        busy <= 1'b1;
      end else if (do_abort) begin
        busy <= 1'b0;
      end else if (do_advance && col_end && row_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      left_column    <= entry_x;
      current_column <= entry_x;
      current_row    <= entry_y;
      end_column     <= entry_end_col;
      end_row        <= entry_end_row;
      held_colour    <= entry_colour;
      row_address    <= start_row_address;
    end else if (do_advance) begin
      if (!col_end) begin
        current_column <= PosW'(col_inc);
      end else if (!row_end) begin
        current_column <= left_column;
        current_row    <= PosW'(row_inc);
        row_address    <= next_row_address;
      end
    end
    if (do_advance) begin
      write_address <= rfpw_pkg::OutAddrW'(pixel_address);
      write_data    <= four_bytes ? held_colour : {rfpw_pkg::BYTE_ZERO, held_colour[23:0]};
      byte_count    <= four_bytes ? rfpw_pkg::BYTES_4 : rfpw_pkg::BYTES_3;
      last          <= col_end && row_end;
    end
  end

endmodule

// ===== hw/rtl/rect_fill_pixel_writer.sv =====
// rect_fill_pixel_writer: top level of the rectangle fill engine
// holds the configuration registers; instantiates rfpw_front, rfpw_queue, rfpw_back
//
// A start word (tuser = 0) loads a rectangle and a colour; the rectangle is clipped
// to the screen and dropped when the block is disabled, the depth is not 24 or 32 bits,
// the origin lies off screen or a side is zero. Each advance word (tuser = 1) then
// yields one pixel write, row by row and left to right, at base + row*pitch +
// column*bytes, with tlast on the final pixel; an advance with no fill running gives
// nothing. The block takes one word per clock while the queue has room and gives up to
// one pixel write per clock: the front classifies and clips in the accepting cycle and
// forms row*pitch with one 16-bit multiplier, a two-entry queue follows, and the back
// updates its counters and loads the output register per entry; a taken advance word
// passes the queue and then the output register. Either side may stall without stopping
// the other until the queue is full. Configuration must be written by the user only while
// no word waits in the queue or at the output; the block itself does not enforce this.

module rect_fill_pixel_writer #(
  parameter int MAX_SIDE     = 8192,
  parameter int ADDRESS_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // rect_x, rect_y, rect_width, rect_height, fill_colour
  input  logic        s_tuser,   // cmd
  // pixel writes
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // write_address, write_data, byte_count, zero pad
  output logic        m_tlast
);

  localparam int PosW   = $clog2(MAX_SIDE);
  localparam int EndW   = $clog2(MAX_SIDE + 1);
  localparam int ProdW  = PosW + rfpw_pkg::PitchW;
  localparam int QueueW = 1 + 2 * PosW + 2 * EndW + 32 + ProdW;

  rfpw_pkg::cfg_t cfg;

  // front to queue
  logic              push;
  logic              f_kind;
  logic [PosW-1:0]   f_x;
  logic [PosW-1:0]   f_y;
  logic [EndW-1:0]   f_end_col;
  logic [EndW-1:0]   f_end_row;
  logic [31:0]       f_colour;
  logic [ProdW-1:0]  f_prod;

  // queue to back
  logic              q_full;
  logic              q_not_empty;
  logic              pop;
  logic [QueueW-1:0] q_rdata;
  logic              b_kind;
  logic [PosW-1:0]   b_x;
  logic [PosW-1:0]   b_y;
  logic [EndW-1:0]   b_end_col;
  logic [EndW-1:0]   b_end_row;
  logic [31:0]       b_colour;
  logic [ProdW-1:0]  b_prod;

  // output fields
  logic [rfpw_pkg::OutAddrW-1:0] write_address;
  logic [31:0]                   write_data;
  logic [2:0]                    byte_count;

  // configuration registers, each masked to its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_enable    <= 1'b0;
      cfg.screen_width   <= '0;
      cfg.screen_height  <= '0;
      cfg.line_pitch     <= '0;
      cfg.bits_per_pixel <= rfpw_pkg::BPP_32;
      cfg.base_address   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfpw_pkg::REG_FILL_ENABLE:    cfg.fill_enable    <= cfg_data[0];
        rfpw_pkg::REG_SCREEN_WIDTH:   cfg.screen_width   <= cfg_data[rfpw_pkg::SideW-1:0];
        rfpw_pkg::REG_SCREEN_HEIGHT:  cfg.screen_height  <= cfg_data[rfpw_pkg::SideW-1:0];
        rfpw_pkg::REG_LINE_PITCH:     cfg.line_pitch     <= cfg_data[rfpw_pkg::PitchW-1:0];
        rfpw_pkg::REG_BITS_PER_PIXEL: cfg.bits_per_pixel <= cfg_data[7:0];
        rfpw_pkg::REG_BASE_ADDRESS:   cfg.base_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a word is taken whenever the queue has room
  assign s_tready = !q_full;

  rfpw_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .word_accept   (s_tvalid && s_tready),
    .cmd           (s_tuser),
    .rect_x        (s_tdata[15:0]),
    .rect_y        (s_tdata[31:16]),
    .rect_width    (s_tdata[47:32]),
    .rect_height   (s_tdata[63:48]),
    .fill_colour   (s_tdata[95:64]),
    .cfg           (cfg),
    .push          (push),
    .entry_kind    (f_kind),
    .entry_x       (f_x),
    .entry_y       (f_y),
    .entry_end_col (f_end_col),
    .entry_end_row (f_end_row),
    .entry_colour  (f_colour),
    .entry_prod    (f_prod)
  );

  rfpw_queue #(
    .WIDTH(QueueW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({f_kind, f_x, f_y, f_end_col, f_end_row, f_colour, f_prod}),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  assign {b_kind, b_x, b_y, b_end_col, b_end_row, b_colour, b_prod} = q_rdata;

  rfpw_back #(
    .MAX_SIDE     (MAX_SIDE),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .entry_valid   (q_not_empty),
    .entry_kind    (b_kind),
    .entry_x       (b_x),
    .entry_y       (b_y),
    .entry_end_col (b_end_col),
    .entry_end_row (b_end_row),
    .entry_colour  (b_colour),
    .entry_prod    (b_prod),
    .pop           (pop),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .write_address (write_address),
    .write_data    (write_data),
    .byte_count    (byte_count),
    .last          (m_tlast)
  );

  // pack the write word, first field lowest
  assign m_tdata = {5'b00000, byte_count, write_data, write_address};

endmodule

// ===== hw/rtl/rfpw_checker.sv =====
// rfpw_checker: port-level assertions for rect_fill_pixel_writer, bound to the top
// depends on rfpw_pkg

module rfpw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tlast
);

  // a stalled write holds its word
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("pixel write changed while stalled");

  // every write carries 3 or 4 bytes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[82:80] == rfpw_pkg::BYTES_3) ||
                 (m_tdata[82:80] == rfpw_pkg::BYTES_4))
    else $error("bad byte count");

  // a 3-byte write has a clear top byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[82:80] == rfpw_pkg::BYTES_3) |->
      (m_tdata[79:72] == rfpw_pkg::BYTE_ZERO))
    else $error("3-byte write with nonzero top byte");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("write valid after reset");

endmodule

bind rect_fill_pixel_writer rfpw_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for the rectangle fill pixel writer
// drives start/advance words and config writes, predicts every pixel write in place
// depends on rfpw_pkg and rect_fill_pixel_writer

module tb_top;

  localparam int FILL_MAX_SIDE = 8192;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 42;
  // cycles allowed after the last write for no-write words still in the pipe
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam logic [2:0] NO_WRITE = 3'd0;

  // one pixel write as it leaves the block
  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } pix_t;

  // one row of the directed table: a register write or a word
  typedef struct {
    bit          is_reg;
    logic [2:0]  idx;
    logic [47:0] val;
    logic        cmd;
    logic [15:0] x, y, w, h;
    logic [31:0] colour;
    bit          typed;
    pix_t        pix;
  } step_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // rect_x, rect_y, rect_width, rect_height, fill_colour
  logic        s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;   // write_address, write_data, byte_count, zero pad
  logic        m_tlast;

  rect_fill_pixel_writer #(
    .MAX_SIDE    (FILL_MAX_SIDE),
    .ADDRESS_BITS(48)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // shadow of the config registers, as written through the port
  rfpw_pkg::cfg_t cfg_shadow = '{fill_enable: 1'b0, screen_width: '0, screen_height: '0,
                                 line_pitch: '0, bits_per_pixel: rfpw_pkg::BPP_32,
                                 base_address: '0};

  // fill state of the predictor
  bit          fill_busy     = 1'b0;
  int unsigned fill_left     = 0;
  int unsigned fill_col      = 0;
  int unsigned fill_row      = 0;
  int unsigned fill_end_col  = 0;
  int unsigned fill_end_row  = 0;
  logic [31:0] fill_colour   = '0;
  logic [47:0] fill_row_addr = '0;

  pix_t        pending_pixels[$];   // writes still owed by the block, oldest first
  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned tx_idle_pct  = 31;
  int unsigned rx_idle_pct  = 56;

  // directed rows may carry a hand-typed write in place of the predicted one
  bit          row_typed = 1'b0;
  pix_t        row_pix   = '0;

  // bytes per pixel for the current depth, NO_WRITE when the depth is unusable
  function automatic logic [2:0] depth_bytes();
    if (cfg_shadow.bits_per_pixel == rfpw_pkg::BPP_32) return rfpw_pkg::BYTES_4;
    if (cfg_shadow.bits_per_pixel == rfpw_pkg::BPP_24) return rfpw_pkg::BYTES_3;
    return NO_WRITE;
  endfunction

  function automatic int unsigned clip_side(logic [13:0] s);
    return (s > FILL_MAX_SIDE) ? FILL_MAX_SIDE : s;
  endfunction

  // apply one accepted word to the predicted fill state; hit says a write comes out
  task automatic paint_step(input logic cmd, input logic [95:0] payload,
                            output bit hit, output pix_t p);
    int unsigned sw, sh, x, y, w, h, ec, er, nb;
    bit          col_end, row_end;
    hit = 1'b0;
    p   = '0;
    nb  = depth_bytes();
    if (cmd == rfpw_pkg::CMD_START) begin
      x  = payload[15:0];
      y  = payload[31:16];
      w  = payload[47:32];
      h  = payload[63:48];
      sw = clip_side(cfg_shadow.screen_width);
      sh = clip_side(cfg_shadow.screen_height);
      // a dropped start leaves any running fill untouched
      if (cfg_shadow.fill_enable && nb != 0 && x < sw && y < sh && w != 0 && h != 0) begin
        // sums are wide here, so a rectangle past the edge clips instead of wrapping
        ec = (x + w > sw) ? sw : x + w;
        er = (y + h > sh) ? sh : y + h;
        fill_busy     = 1'b1;
        fill_left     = x;
        fill_col      = x;
        fill_row      = y;
        fill_end_col  = ec;
        fill_end_row  = er;
        fill_colour   = payload[95:64];
        fill_row_addr = cfg_shadow.base_address + 48'(y) * 48'(cfg_shadow.line_pitch);
      end
    end else if (fill_busy) begin
      if (!cfg_shadow.fill_enable || nb == 0) begin
        // framebuffer gone or depth broken mid-fill: fill is dropped silently
        fill_busy = 1'b0;
      end else begin
        col_end  = (fill_col + 1 >= fill_end_col);
        row_end  = (fill_row + 1 >= fill_end_row);
        hit      = 1'b1;
        p.addr   = fill_row_addr + 48'(fill_col * nb);
        p.data   = (nb == rfpw_pkg::BYTES_3) ? {rfpw_pkg::BYTE_ZERO, fill_colour[23:0]}
                                             : fill_colour;
        p.nbytes = 3'(nb);
        p.last   = col_end && row_end;
        if (!col_end) begin
          fill_col = fill_col + 1;
        end else if (!row_end) begin
          // pitch in force now is what steps to the next row
          fill_col      = fill_left;
          fill_row      = fill_row + 1;
          fill_row_addr = fill_row_addr + 48'(cfg_shadow.line_pitch);
        end else begin
          fill_busy = 1'b0;
        end
      end
    end
  endtask

  // handshake monitor: predicts on every accepted word, checks every accepted write
  always @(posedge clk) begin
    bit   hit;
    pix_t want;
    pix_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        paint_step(s_tuser, s_tdata, hit, want);
        if (row_typed) pending_pixels.push_back(row_pix);
        else if (hit) pending_pixels.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = '{addr: m_tdata[47:0], data: m_tdata[79:48], nbytes: m_tdata[82:80],
                last: m_tlast};
        if (pending_pixels.size() == 0) begin
          error_count++;
          $display("%0t unexpected write: expected none, got addr=%h data=%h bytes=%0d last=%0b",
                   $time, got.addr, got.data, got.nbytes, got.last);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t write mismatch: expected addr=%h data=%h bytes=%0d last=%0b",
                     $time, want.addr, want.data, want.nbytes, want.last);
            $display("%0t                 got      addr=%h data=%h bytes=%0d last=%0b",
                     $time, got.addr, got.data, got.nbytes, got.last);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog: too long with no word moving on either side
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // present one word, with random idle cycles ahead of it; returns after a falling edge
  task automatic send_word(input logic cmd, input logic [95:0] payload);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = payload;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold the sender off until every owed write is out and the pipe has emptied
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      rfpw_pkg::REG_FILL_ENABLE:    cfg_shadow.fill_enable    = val[0];
      rfpw_pkg::REG_SCREEN_WIDTH:   cfg_shadow.screen_width   = val[13:0];
      rfpw_pkg::REG_SCREEN_HEIGHT:  cfg_shadow.screen_height  = val[13:0];
      rfpw_pkg::REG_LINE_PITCH:     cfg_shadow.line_pitch     = val[15:0];
      rfpw_pkg::REG_BITS_PER_PIXEL: cfg_shadow.bits_per_pixel = val[7:0];
      rfpw_pkg::REG_BASE_ADDRESS:   cfg_shadow.base_address   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic step_t reg_row(logic [2:0] idx, logic [47:0] val);
    step_t r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic step_t word_row(logic cmd, logic [15:0] x, logic [15:0] y,
                                     logic [15:0] w, logic [15:0] h, logic [31:0] colour);
    step_t r = '{default: '0};
    r.cmd    = cmd;
    r.x      = x;
    r.y      = y;
    r.w      = w;
    r.h      = h;
    r.colour = colour;
    return r;
  endfunction

  // advance whose write is obvious from the rectangle at hand
  function automatic step_t pix_row(logic [47:0] addr, logic [31:0] data,
                                    logic [2:0] nbytes, logic last);
    step_t r = '{default: '0};
    r.cmd   = rfpw_pkg::CMD_ADVANCE;
    r.typed = 1'b1;
    r.pix   = '{addr: addr, data: data, nbytes: nbytes, last: last};
    return r;
  endfunction

  // screen side: mostly tiny so fills finish, plus zero, the clip size, all ones and any value
  function automatic logic [47:0] pick_side();
    case ($urandom_range(9))
      0:       return 48'd0;
      1:       return 48'(FILL_MAX_SIDE);
      2:       return 48'h3FFF;
      3:       return 48'($urandom_range(16383));
      default: return 48'($urandom_range(40, 1));
    endcase
  endfunction

  initial begin
    step_t       plan[$];
    int unsigned sw, sh, x, y, w, h, ec, er, npix, sent, pick;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tuser   = rfpw_pkg::CMD_START;
    s_tdata   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    // out of reset the framebuffer is absent: start dropped, advance with no fill
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd0, 16'd1, 16'd1, 32'hDEADBEEF));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));
    // oversize screen clips to the max side; base near the top of the address space
    plan.push_back(reg_row(rfpw_pkg::REG_FILL_ENABLE, 48'd1));
    plan.push_back(reg_row(rfpw_pkg::REG_SCREEN_WIDTH, 48'h3FFF));
    plan.push_back(reg_row(rfpw_pkg::REG_SCREEN_HEIGHT, 48'h3FFF));
    plan.push_back(reg_row(rfpw_pkg::REG_LINE_PITCH, 48'hFFFF));
    plan.push_back(reg_row(rfpw_pkg::REG_BASE_ADDRESS, 48'hFFFF_FFFF_FFF0));
    // corner pixel with maximal sides: sums must not wrap, address does
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd8191, 16'd8191, 16'hFFFF, 16'hFFFF,
                            32'hFFFFFFFF));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));
    // plain 2x2 at the origin, 32-bit depth
    plan.push_back(reg_row(rfpw_pkg::REG_BASE_ADDRESS, 48'd0));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd0, 16'd2, 16'd2, 32'h12345678));
    plan.push_back(pix_row(48'd0,     32'h12345678, rfpw_pkg::BYTES_4, 1'b0));
    plan.push_back(pix_row(48'd4,     32'h12345678, rfpw_pkg::BYTES_4, 1'b0));
    plan.push_back(pix_row(48'd65535, 32'h12345678, rfpw_pkg::BYTES_4, 1'b0));
    plan.push_back(pix_row(48'd65539, 32'h12345678, rfpw_pkg::BYTES_4, 1'b1));
    // four ways a start is dropped: origin off screen in x or in y, zero width, zero height
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd8192, 16'd0, 16'd1, 16'd1, 32'h1));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd8192, 16'd1, 16'd1, 32'h1));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd0, 16'd0, 16'd1, 32'h1));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd0, 16'd1, 16'd0, 32'h1));
    // 24-bit depth: three-byte writes, top byte cleared; restart while busy
    plan.push_back(reg_row(rfpw_pkg::REG_BITS_PER_PIXEL, 48'(rfpw_pkg::BPP_24)));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd1, 16'd0, 16'd3, 16'd1, 32'hAABBCCDD));
    plan.push_back(pix_row(48'd3, 32'h00BBCCDD, rfpw_pkg::BYTES_3, 1'b0));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd0, 16'd1, 16'd1, 32'h11223344));
    plan.push_back(pix_row(48'd0, 32'h00223344, rfpw_pkg::BYTES_3, 1'b1));
    // a dropped start in the middle of a fill leaves it running
    plan.push_back(reg_row(rfpw_pkg::REG_BITS_PER_PIXEL, 48'(rfpw_pkg::BPP_32)));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd0, 16'd0, 16'd2, 16'd1, 32'hC0FFEE00));
    plan.push_back(pix_row(48'd0, 32'hC0FFEE00, rfpw_pkg::BYTES_4, 1'b0));
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'hFFFF, 16'd0, 16'd1, 16'd1, 32'h1));
    plan.push_back(pix_row(48'd4, 32'hC0FFEE00, rfpw_pkg::BYTES_4, 1'b1));
    // pitch and base rewritten mid-fill, then the depth broken under it
    plan.push_back(word_row(rfpw_pkg::CMD_START, 16'd3, 16'd2, 16'd2, 16'd2, 32'h0BADF00D));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));
    plan.push_back(reg_row(rfpw_pkg::REG_LINE_PITCH, 48'd100));
    plan.push_back(reg_row(rfpw_pkg::REG_BASE_ADDRESS, 48'h1234_5678));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));
    plan.push_back(reg_row(rfpw_pkg::REG_BITS_PER_PIXEL, 48'd16));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));
    plan.push_back(reg_row(rfpw_pkg::REG_BITS_PER_PIXEL, 48'(rfpw_pkg::BPP_32)));
    plan.push_back(word_row(rfpw_pkg::CMD_ADVANCE, '0, '0, '0, '0, '0));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        row_typed = plan[i].typed;
        row_pix   = plan[i].pix;
        if (plan[i].cmd == rfpw_pkg::CMD_START)
          send_word(rfpw_pkg::CMD_START,
                    {plan[i].colour, plan[i].h, plan[i].w, plan[i].y, plan[i].x});
        else
          send_word(rfpw_pkg::CMD_ADVANCE, {$urandom, $urandom, $urandom});
      end
    end
    row_typed = 1'b0;

    // random phases; registers only change between them, with the block drained
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph * 3 / NUM_PHASES)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 0 || $urandom_range(1))
        write_reg(rfpw_pkg::REG_FILL_ENABLE, 48'($urandom_range(9) != 0));
      if (ph == 0 || $urandom_range(1)) write_reg(rfpw_pkg::REG_SCREEN_WIDTH, pick_side());
      if (ph == 0 || $urandom_range(1)) write_reg(rfpw_pkg::REG_SCREEN_HEIGHT, pick_side());
      if (ph == 0 || $urandom_range(1)) begin
        case ($urandom_range(5))
          0:       write_reg(rfpw_pkg::REG_LINE_PITCH, 48'd0);
          1:       write_reg(rfpw_pkg::REG_LINE_PITCH, 48'hFFFF);
          default: write_reg(rfpw_pkg::REG_LINE_PITCH, 48'($urandom_range(65535)));
        endcase
      end
      if (ph == 0 || $urandom_range(1)) begin
        case ($urandom_range(11))
          0:       write_reg(rfpw_pkg::REG_BITS_PER_PIXEL, 48'($urandom_range(255)));
          1:       write_reg(rfpw_pkg::REG_BITS_PER_PIXEL, 48'hFF);
          2:       write_reg(rfpw_pkg::REG_BITS_PER_PIXEL, 48'd0);
          3, 4, 5, 6: write_reg(rfpw_pkg::REG_BITS_PER_PIXEL, 48'(rfpw_pkg::BPP_24));
          default: write_reg(rfpw_pkg::REG_BITS_PER_PIXEL, 48'(rfpw_pkg::BPP_32));
        endcase
      end
      if (ph == 0 || $urandom_range(1)) begin
        case ($urandom_range(5))
          0:       write_reg(rfpw_pkg::REG_BASE_ADDRESS, 48'd0);
          1:       write_reg(rfpw_pkg::REG_BASE_ADDRESS, 48'hFFFF_FFFF_FFFF);
          default: write_reg(rfpw_pkg::REG_BASE_ADDRESS,
                             {16'($urandom_range(65535)), 32'($urandom)});
        endcase
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        sw   = clip_side(cfg_shadow.screen_width);
        sh   = clip_side(cfg_shadow.screen_height);
        pick = $urandom_range(99);
        // now and then let every owed write come out before going on
        if (pick < 3) wait_drained();
        if (pick < 75 && sw != 0 && sh != 0) begin
          // on-screen rectangle, then about as many advances as it has pixels
          x = $urandom_range(sw - 1);
          y = $urandom_range(sh - 1);
          w = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(6, 1);
          h = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(4, 1);
          ec = (x + w > sw) ? sw : x + w;
          er = (y + h > sh) ? sh : y + h;
          npix = (ec - x) * (er - y);
          if (npix > 30) npix = 30;   // long fills get cut short by the next start
          send_word(rfpw_pkg::CMD_START, {32'($urandom), 16'(h), 16'(w), 16'(y), 16'(x)});
          repeat (npix + (($urandom_range(3) == 0) ? 1 : 0))
            send_word(rfpw_pkg::CMD_ADVANCE, {$urandom, $urandom, $urandom});
          sent += 1 + npix;
        end else if (pick < 90) begin
          // full-range start, mostly off screen
          send_word(rfpw_pkg::CMD_START, {$urandom, $urandom, $urandom});
          sent++;
        end else begin
          send_word(rfpw_pkg::CMD_ADVANCE, {$urandom, $urandom, $urandom});
          sent++;
        end
      end
    end

    wait_drained();
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rfpw_pkg.sv
hw/rtl/rfpw_front.sv
hw/rtl/rfpw_queue.sv
hw/rtl/rfpw_back.sv
hw/rtl/rect_fill_pixel_writer.sv
hw/rtl/rfpw_checker.sv
sim/tb_top.sv
